FILE: src/ipt_pkg.sv
package ipt_pkg;

   // Defaults for the top-level parameters
   localparam int PATCH_SIDE_DEF      = 16;
   localparam int TEMPORAL_COPIES_DEF = 2;

   // Fixed geometry and field widths
   localparam int CHANNELS    = 3;
   localparam int MAX_PATCHES = 8192;
   localparam int GRID_W      = 14;
   localparam int GRID_MAX    = 8192;
   localparam int GRID_RESET  = 32;
   localparam int PGRID_W     = 13;
   localparam int PATCH_W     = 27;
   localparam int ADDR_W      = 24;
   localparam int VALUE_W     = 16;
   localparam int BYTE_W      = 8;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 14;
   localparam int NORM_DEPTH  = 256;

   typedef logic [BYTE_W-1:0]                    byte_type;
   typedef logic [ADDR_W-1:0]                    addr_type;
   typedef logic signed [VALUE_W-1:0]            value_type;
   typedef logic [GRID_W-1:0]                    grid_type;
   typedef logic [NORM_DEPTH-1:0][VALUE_W-1:0]   norm_table_type;

   // Register indexes on the csr port
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_GRID_WIDTH  = 2'd0,
      CSR_GRID_HEIGHT = 2'd1
   } csr_index_type;

   // Colour channel of one output word, in emission order
   typedef enum logic [1:0] {
      CH_RED   = 2'd0,
      CH_GREEN = 2'd1,
      CH_BLUE  = 2'd2
   } chan_type;

   // Q1.14 code of each byte: floor(2*b*16384/255 + 1/2) - 16384
   function automatic norm_table_type build_norm_table();
      norm_table_type tbl;
      int             up;
      for (int i = 0; i < NORM_DEPTH; i++) begin
         up     = (i * 65536 + 255) / 510;
         tbl[i] = VALUE_W'(up - 16384);
      end
      return tbl;
   endfunction

   localparam norm_table_type NORM_TABLE = build_norm_table();

   // Grid register write: zero holds one, anything above the maximum holds the maximum
   function automatic grid_type grid_clamp(input logic [CSR_DATA_W-1:0] v);
      grid_type g;
      g = GRID_W'(v);
      if (g == '0) begin
         g = GRID_W'(1);
      end else if (g > GRID_W'(GRID_MAX)) begin
         g = GRID_W'(GRID_MAX);
      end
      return g;
   endfunction

endpackage

FILE: src/ipt_if.sv
// Pixel channel: one RGB pixel per word
interface ipt_pixel_if;
   import ipt_pkg::*;

   logic     valid;
   logic     ready;
   byte_type red;
   byte_type green;
   byte_type blue;

   modport source (output valid, red, green, blue, input ready);
   modport sink   (input valid, red, green, blue, output ready);
endinterface

// Write channel: one patch-tensor element per word
interface ipt_write_if;
   import ipt_pkg::*;

   logic      valid;
   logic      ready;
   addr_type  address;
   value_type value;
   logic      run_last;
   logic      frame_last;
   logic      range_error;

   modport source (output valid, address, value, run_last, frame_last, range_error,
                   input ready);
   modport sink   (input valid, address, value, run_last, frame_last, range_error,
                   output ready);
endinterface

FILE: src/image_patch_tokenizer_top.sv
// Pipeline: each pixel passes through stage 1, stage 2, the stage 3 sequencer and the output
// register; the sequencer then issues the remaining words of the pixel.
// Throughput: one word per cycle through the single output register while rsp_if.ready allows
// it; the two front stages overlap with the sequencer.
// Reset: synchronous, active high; clears all valid flags and the pixel counters and
// loads both grid registers with 32 patches.
module image_patch_tokenizer_top #(
   parameter int PATCH_SIDE      = ipt_pkg::PATCH_SIDE_DEF,
   parameter int TEMPORAL_COPIES = ipt_pkg::TEMPORAL_COPIES_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   ipt_pixel_if.sink                        req_if,
   ipt_write_if.source                      rsp_if,
   input  logic                             csr_write_enable,
   input  logic [ipt_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [ipt_pkg::CSR_DATA_W-1:0]   csr_write_data
);
   import ipt_pkg::*;

   localparam int SIDE_W    = $clog2(PATCH_SIDE);
   localparam int PLANE     = PATCH_SIDE * PATCH_SIDE;
   localparam int LOCAL_W   = $clog2(PLANE);
   localparam int CH_STRIDE = TEMPORAL_COPIES * PLANE;
   localparam int PER_PATCH = CHANNELS * CH_STRIDE;
   localparam int COPY_W    = (TEMPORAL_COPIES > 1) ? $clog2(TEMPORAL_COPIES) : 1;

   localparam logic [SIDE_W-1:0] SIDE_LAST = SIDE_W'(PATCH_SIDE - 1);
   localparam logic [COPY_W-1:0] COPY_LAST = COPY_W'(TEMPORAL_COPIES - 1);
   localparam addr_type CHAN_STEP = ADDR_W'(CH_STRIDE);
   localparam addr_type COPY_STEP = ADDR_W'(PLANE) - ADDR_W'((CHANNELS - 1) * CH_STRIDE);

   // Grid registers
   grid_type grid_width_ff, grid_width_in;
   grid_type grid_height_ff, grid_height_in;

   // Position of the next pixel: patch column/row and place inside the patch
   logic [PGRID_W-1:0] pcol_ff, pcol_in;
   logic [PGRID_W-1:0] prow_ff, prow_in;
   logic [SIDE_W-1:0]  cip_ff, cip_in;
   logic [SIDE_W-1:0]  rip_ff, rip_in;

   // Stage 1: normalised pixel and its position
   logic               p1_valid_ff, p1_valid_in;
   value_type          p1_value_ff [CHANNELS];
   value_type          p1_value_in [CHANNELS];
   logic [PGRID_W-1:0] p1_pcol_ff, p1_pcol_in;
   logic [PGRID_W-1:0] p1_prow_ff, p1_prow_in;
   logic [SIDE_W-1:0]  p1_cip_ff, p1_cip_in;
   logic [SIDE_W-1:0]  p1_rip_ff, p1_rip_in;
   logic               p1_frame_end_ff, p1_frame_end_in;

   // Stage 2: patch index and offset inside the patch
   logic               p2_valid_ff, p2_valid_in;
   value_type          p2_value_ff [CHANNELS];
   value_type          p2_value_in [CHANNELS];
   logic [PATCH_W-1:0] p2_patch_ff, p2_patch_in;
   logic [LOCAL_W-1:0] p2_local_ff, p2_local_in;
   logic               p2_frame_end_ff, p2_frame_end_in;

   // Stage 3: word sequencer over copies and channels
   logic               s3_valid_ff, s3_valid_in;
   value_type          s3_value_ff [CHANNELS];
   value_type          s3_value_in [CHANNELS];
   addr_type           s3_base_ff, s3_base_in;
   addr_type           s3_off_ff, s3_off_in;
   logic               s3_err_ff, s3_err_in;
   logic               s3_frame_end_ff, s3_frame_end_in;
   chan_type           s3_chan_ff, s3_chan_in;
   logic [COPY_W-1:0]  s3_copy_ff, s3_copy_in;

   // Output register
   logic      rsp_valid_ff, rsp_valid_in;
   addr_type  rsp_address_ff, rsp_address_in;
   value_type rsp_value_ff, rsp_value_in;
   logic      rsp_run_last_ff, rsp_run_last_in;
   logic      rsp_frame_last_ff, rsp_frame_last_in;
   logic      rsp_range_error_ff, rsp_range_error_in;

   // Flow control
   logic out_free, emit, s3_last, s3_free;
   logic p2_move, p2_free, p1_move, p1_free, req_take;
   logic [PGRID_W-1:0] gw_last, gh_last;
   logic row_end, frame_end;

   assign out_free = !rsp_valid_ff || rsp_if.ready;
   assign emit     = s3_valid_ff && out_free;
   assign s3_last  = (s3_chan_ff == CH_BLUE) && (s3_copy_ff == COPY_LAST);
   assign s3_free  = !s3_valid_ff || (emit && s3_last);
   assign p2_move  = p2_valid_ff && s3_free;
   assign p2_free  = !p2_valid_ff || s3_free;
   assign p1_move  = p1_valid_ff && p2_free;
   assign p1_free  = !p1_valid_ff || p2_free;
   assign req_take = req_if.valid && p1_free;

   assign req_if.ready = p1_free;

   // Row and frame end, also for positions past a grid shrunk mid-frame
   assign gw_last   = PGRID_W'(grid_width_ff - GRID_W'(1));
   assign gh_last   = PGRID_W'(grid_height_ff - GRID_W'(1));
   assign row_end   = (pcol_ff > gw_last) || ((pcol_ff == gw_last) && (cip_ff == SIDE_LAST));
   assign frame_end = row_end &&
                      ((prow_ff > gh_last) || ((prow_ff == gh_last) && (rip_ff == SIDE_LAST)));

   // Configuration writes
   always_comb begin
      grid_width_in  = grid_width_ff;
      grid_height_in = grid_height_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_GRID_WIDTH:  grid_width_in  = grid_clamp(csr_write_data);
            CSR_GRID_HEIGHT: grid_height_in = grid_clamp(csr_write_data);
            default: ;
         endcase
      end
   end

   // Pixel position counters
   always_comb begin
      pcol_in = pcol_ff;
      prow_in = prow_ff;
      cip_in  = cip_ff;
      rip_in  = rip_ff;
      if (req_take) begin
         if (frame_end) begin
            pcol_in = '0;
            prow_in = '0;
            cip_in  = '0;
            rip_in  = '0;
         end else if (row_end) begin
            pcol_in = '0;
            cip_in  = '0;
            if (rip_ff == SIDE_LAST) begin
               rip_in  = '0;
               prow_in = prow_ff + PGRID_W'(1);
            end else begin
               rip_in = rip_ff + SIDE_W'(1);
            end
         end else if (cip_ff == SIDE_LAST) begin
            cip_in  = '0;
            pcol_in = pcol_ff + PGRID_W'(1);
         end else begin
            cip_in = cip_ff + SIDE_W'(1);
         end
      end
   end

   // Stage 1: table lookup and position snapshot
   always_comb begin
      p1_valid_in     = req_take ? 1'b1 : (p2_free ? 1'b0 : p1_valid_ff);
      p1_value_in     = p1_value_ff;
      p1_pcol_in      = p1_pcol_ff;
      p1_prow_in      = p1_prow_ff;
      p1_cip_in       = p1_cip_ff;
      p1_rip_in       = p1_rip_ff;
      p1_frame_end_in = p1_frame_end_ff;
      if (req_take) begin
         p1_value_in[CH_RED]   = NORM_TABLE[req_if.red];
         p1_value_in[CH_GREEN] = NORM_TABLE[req_if.green];
         p1_value_in[CH_BLUE]  = NORM_TABLE[req_if.blue];
         p1_pcol_in            = pcol_ff;
         p1_prow_in            = prow_ff;
         p1_cip_in             = cip_ff;
         p1_rip_in             = rip_ff;
         p1_frame_end_in       = frame_end;
      end
   end

   // Stage 2: patch = patch_row * grid_width + patch_col
   always_comb begin
      p2_valid_in     = p1_move ? 1'b1 : (s3_free ? 1'b0 : p2_valid_ff);
      p2_value_in     = p2_value_ff;
      p2_patch_in     = p2_patch_ff;
      p2_local_in     = p2_local_ff;
      p2_frame_end_in = p2_frame_end_ff;
      if (p1_move) begin
         p2_value_in     = p1_value_ff;
         p2_patch_in     = PATCH_W'(p1_prow_ff) * PATCH_W'(grid_width_ff) +
                           PATCH_W'(p1_pcol_ff);
         p2_local_in     = LOCAL_W'(p1_rip_ff) * LOCAL_W'(PATCH_SIDE) + LOCAL_W'(p1_cip_ff);
         p2_frame_end_in = p1_frame_end_ff;
      end
   end

   // Stage 3: base address, then step through copies (outer) and channels (inner)
   always_comb begin
      s3_valid_in     = p2_move ? 1'b1 : (s3_free ? 1'b0 : s3_valid_ff);
      s3_value_in     = s3_value_ff;
      s3_base_in      = s3_base_ff;
      s3_off_in       = s3_off_ff;
      s3_err_in       = s3_err_ff;
      s3_frame_end_in = s3_frame_end_ff;
      s3_chan_in      = s3_chan_ff;
      s3_copy_in      = s3_copy_ff;
      if (p2_move) begin
         s3_value_in     = p2_value_ff;
         s3_base_in      = p2_patch_ff[ADDR_W-1:0] * ADDR_W'(PER_PATCH) +
                           ADDR_W'(p2_local_ff);
         s3_off_in       = '0;
         s3_err_in       = p2_patch_ff >= PATCH_W'(MAX_PATCHES);
         s3_frame_end_in = p2_frame_end_ff;
         s3_chan_in      = CH_RED;
         s3_copy_in      = '0;
      end else if (emit && !s3_last) begin
         case (s3_chan_ff)
            CH_RED: begin
               s3_chan_in = CH_GREEN;
               s3_off_in  = s3_off_ff + CHAN_STEP;
            end
            CH_GREEN: begin
               s3_chan_in = CH_BLUE;
               s3_off_in  = s3_off_ff + CHAN_STEP;
            end
            default: begin
               s3_chan_in = CH_RED;
               s3_copy_in = s3_copy_ff + COPY_W'(1);
               s3_off_in  = s3_off_ff + COPY_STEP;
            end
         endcase
      end
   end

   // Output register
   always_comb begin
      rsp_valid_in       = emit ? 1'b1 : (rsp_if.ready ? 1'b0 : rsp_valid_ff);
      rsp_address_in     = rsp_address_ff;
      rsp_value_in       = rsp_value_ff;
      rsp_run_last_in    = rsp_run_last_ff;
      rsp_frame_last_in  = rsp_frame_last_ff;
      rsp_range_error_in = rsp_range_error_ff;
      if (emit) begin
         rsp_address_in = s3_base_ff + s3_off_ff;
         case (s3_chan_ff)
            CH_RED:   rsp_value_in = s3_value_ff[CH_RED];
            CH_GREEN: rsp_value_in = s3_value_ff[CH_GREEN];
            default:  rsp_value_in = s3_value_ff[CH_BLUE];
         endcase
         rsp_run_last_in    = s3_last;
         rsp_frame_last_in  = s3_frame_end_ff;
         rsp_range_error_in = s3_err_ff;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         grid_width_ff  <= GRID_W'(GRID_RESET);
         grid_height_ff <= GRID_W'(GRID_RESET);
         pcol_ff        <= '0;
         prow_ff        <= '0;
         cip_ff         <= '0;
         rip_ff         <= '0;
         p1_valid_ff    <= 1'b0;
         p2_valid_ff    <= 1'b0;
         s3_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         grid_width_ff  <= grid_width_in;
         grid_height_ff <= grid_height_in;
         pcol_ff        <= pcol_in;
         prow_ff        <= prow_in;
         cip_ff         <= cip_in;
         rip_ff         <= rip_in;
         p1_valid_ff    <= p1_valid_in;
         p2_valid_ff    <= p2_valid_in;
         s3_valid_ff    <= s3_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      p1_value_ff        <= p1_value_in;
      p1_pcol_ff         <= p1_pcol_in;
      p1_prow_ff         <= p1_prow_in;
      p1_cip_ff          <= p1_cip_in;
      p1_rip_ff          <= p1_rip_in;
      p1_frame_end_ff    <= p1_frame_end_in;
      p2_value_ff        <= p2_value_in;
      p2_patch_ff        <= p2_patch_in;
      p2_local_ff        <= p2_local_in;
      p2_frame_end_ff    <= p2_frame_end_in;
      s3_value_ff        <= s3_value_in;
      s3_base_ff         <= s3_base_in;
      s3_off_ff          <= s3_off_in;
      s3_err_ff          <= s3_err_in;
      s3_frame_end_ff    <= s3_frame_end_in;
      s3_chan_ff         <= s3_chan_in;
      s3_copy_ff         <= s3_copy_in;
      rsp_address_ff     <= rsp_address_in;
      rsp_value_ff       <= rsp_value_in;
      rsp_run_last_ff    <= rsp_run_last_in;
      rsp_frame_last_ff  <= rsp_frame_last_in;
      rsp_range_error_ff <= rsp_range_error_in;
   end

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.address     = rsp_address_ff;
   assign rsp_if.value       = rsp_value_ff;
   assign rsp_if.run_last    = rsp_run_last_ff;
   assign rsp_if.frame_last  = rsp_frame_last_ff;
   assign rsp_if.range_error = rsp_range_error_ff;

`ifndef NO_ASSERTIONS
   // Last pixel of a frame brings the position back to the origin
   a_frame_wrap: assert property (@(posedge clock) disable iff (reset)
      (req_take && frame_end) |=>
         (pcol_ff == '0 && prow_ff == '0 && cip_ff == '0 && rip_ff == '0))
      else $error("pixel position not cleared after the last pixel of a frame");

   // The final word of a pixel lands in the output register flagged as such
   a_last_word: assert property (@(posedge clock) disable iff (reset)
      (emit && s3_last) |=> (rsp_valid_ff && rsp_run_last_ff))
      else $error("last word of a pixel not marked run_last");

   // Sequencer never runs past the last copy
   a_copy_range: assert property (@(posedge clock) disable iff (reset)
      s3_valid_ff |-> (s3_copy_ff <= COPY_LAST))
      else $error("copy counter past the last temporal copy");

   // A stage 2 word blocked by the sequencer is neither lost nor changed
   a_p2_hold: assert property (@(posedge clock) disable iff (reset)
      (p2_valid_ff && !s3_free) |=> (p2_valid_ff && $stable(p2_patch_ff)))
      else $error("stage 2 word overwritten while the sequencer is busy");

   // Position inside a patch stays within the patch side
   a_in_patch: assert property (@(posedge clock) disable iff (reset)
      (cip_ff <= SIDE_LAST) && (rip_ff <= SIDE_LAST))
      else $error("position inside the patch out of range");
`endif

endmodule
